[rtl/core/assert_macros.svh]
// Assertion macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pqe_pkg.sv]
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types and constants of the product-quantization encode/ADC engine.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int MaxSubvectors = 32;
  localparam int Centroids     = 256;
  localparam int MaxSubDim     = 8;

  localparam int SubW   = 5;
  localparam int CentW  = 8;
  localparam int ElemW  = 3;
  localparam int ValW   = 16;
  localparam int DistW  = 38;
  localparam int AccW   = 44;

  // action codes
  localparam logic [1:0] ActWrite  = 2'd0;
  localparam logic [1:0] ActEncode = 2'd1;
  localparam logic [1:0] ActQuery  = 2'd2;
  localparam logic [1:0] ActCode   = 2'd3;

  // config register indexes
  localparam logic RegNumSub = 1'b0;
  localparam logic RegSubDim = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic             load;      // capture input item
    logic             buf_wr;    // write element into subvector buffer
    logic             cent_wr;   // centroid store write
    logic             scan_start;// clear scan state
    logic             scan_step; // process one (centroid,element) pair
    logic             acc_step;  // add table entry to accumulator
    logic             tab_wr;    // commit one table entry
    logic             out_load;  // place result into output register
    logic             out_kind;
  } pqe_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] action;
    logic       sub_end;    // element completes a subvector
    logic       elem_last;  // last element of current centroid
    logic       cent_last;  // last centroid of scan
    logic       code_end;   // code completes a candidate
  } pqe_stat_t;

endpackage

[rtl/core/pqe_ctrl.sv]
// ----------------------------------------------------------------------------
// pqe_ctrl
// Sequencer: accepts one item, runs the centroid scan or table lookup.
// ----------------------------------------------------------------------------
module pqe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  pqe_pkg::pqe_stat_t stat,
  output logic              busy,
  output pqe_pkg::pqe_cmd_t cmd
);
  import pqe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_SCAN, S_DRAIN, S_LOOK, S_ACC, S_OUT
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  // drain counter: waits for the scan pipeline to empty after the last step issue
  logic [1:0] drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) state <= S_DEC;
        S_DEC: begin
          case (stat.action)
            ActWrite: state <= S_IDLE;
            ActCode:  state <= S_LOOK;
            default:  state <= stat.sub_end ? S_SCAN : S_IDLE;
          endcase
        end
        S_SCAN: if (stat.elem_last && stat.cent_last) begin
          state <= S_DRAIN;
          drain <= 2'd3;
        end
        S_DRAIN: begin
          drain <= drain - 2'd1;
          if (drain == 2'd1) state <= (stat.action == ActEncode) ? S_OUT : S_IDLE;
        end
        S_LOOK: state <= S_ACC;
        S_ACC:  state <= stat.code_end ? S_OUT : S_IDLE;
        S_OUT:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load       = in_fire;
    cmd.cent_wr    = (state == S_DEC) && (stat.action == ActWrite);
    cmd.buf_wr     = (state == S_DEC) &&
                     (stat.action == ActEncode || stat.action == ActQuery);
    cmd.scan_start = cmd.buf_wr;
    cmd.scan_step  = (state == S_SCAN);
    cmd.tab_wr     = (stat.action == ActQuery);
    cmd.acc_step   = (state == S_ACC);
    cmd.out_load   = (state == S_OUT) && out_free;
    cmd.out_kind   = (stat.action == ActCode);
  end

endmodule

[rtl/core/pqe_dpath.sv]
// ----------------------------------------------------------------------------
// pqe_dpath
// Datapath: centroid store, distance table, scan pipeline and accumulator.
// ----------------------------------------------------------------------------
module pqe_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  pqe_pkg::pqe_cmd_t    cmd,
  input  logic                 cfg_fire,
  input  logic                 cfg_index,
  input  logic [5:0]           cfg_data,
  input  logic [1:0]           in_action,
  input  logic [4:0]           in_sub,
  input  logic [7:0]           in_cent,
  input  logic [2:0]           in_elem,
  input  logic signed [15:0]   in_value,
  input  logic [7:0]           in_code,
  output pqe_pkg::pqe_stat_t   stat,
  output logic                 res_kind,
  output logic [7:0]           res_code,
  output logic [4:0]           res_sub,
  output logic [43:0]          res_dist,
  output logic                 res_last
);
  import pqe_pkg::*;

  // memories
  logic [ValW-1:0]  cstore [MaxSubvectors*Centroids*MaxSubDim];
  logic [DistW-1:0] dtable [MaxSubvectors*Centroids];
  logic [ValW-1:0]  sbuf   [MaxSubDim];

  // config
  logic [5:0] num_sub;
  logic [3:0] sub_dim;
  logic [5:0] eff_m;
  logic [3:0] eff_d;

  // captured item
  logic [1:0]  act;
  logic [4:0]  sub_sel;
  logic [7:0]  cent_sel;
  logic [2:0]  elem_sel;
  logic [15:0] val;
  logic [7:0]  code;

  // positions
  logic [2:0]  elem_pos;
  logic [4:0]  sub_pos;
  logic [4:0]  code_pos;
  logic [AccW-1:0] acc;
  logic [4:0]  cur_sub;

  // scan counters and pipeline
  logic [7:0]  sc_cent;
  logic [2:0]  sc_elem;
  logic        p1_v, p1_first, p1_lastel;
  logic [7:0]  p1_cent;
  logic [2:0]  p1_elem;
  logic [15:0] p1_cv;
  logic        p2_v, p2_first, p2_lastel;
  logic [7:0]  p2_cent;
  logic [31:0] p2_sq;
  logic [DistW-1:0] dsum;
  logic [DistW-1:0] best;
  logic [7:0]  best_c;
  logic [DistW-1:0] full_d;
  logic [DistW-1:0] tab_q;
  logic [AccW:0]    acc_sum;
  logic signed [16:0] diff;

  always_comb begin
    eff_m = (num_sub == 6'd0) ? 6'd1 : (num_sub > 6'd32) ? 6'd32 : num_sub;
    eff_d = (sub_dim == 4'd0) ? 4'd1 : (sub_dim > 4'd8) ? 4'd8 : sub_dim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sub <= 6'd1;
      sub_dim <= 4'd1;
    end else if (cfg_fire) begin
      if (cfg_index == RegNumSub) num_sub <= cfg_data;
      else sub_dim <= cfg_data[3:0];
    end
  end

  // capture item
  always_ff @(posedge clk) begin
    if (rst) act <= ActWrite;
    else if (cmd.load) act <= in_action;
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sub_sel <= in_sub; cent_sel <= in_cent; elem_sel <= in_elem;
      val <= in_value; code <= in_code;
    end
  end

  // status
  assign stat.action    = act;
  assign stat.sub_end   = ({1'b0, elem_pos} + 4'd1 >= eff_d);
  assign stat.elem_last = ({1'b0, sc_elem} + 4'd1 >= eff_d);
  assign stat.cent_last = (sc_cent == 8'hFF);
  assign stat.code_end  = ({1'b0, code_pos} + 6'd1 >= eff_m);

  // centroid store write
  always_ff @(posedge clk) begin
    if (cmd.cent_wr) cstore[{sub_sel, cent_sel, elem_sel}] <= val;
  end

  // element buffer and positions
  always_ff @(posedge clk) begin
    if (cmd.buf_wr) sbuf[elem_pos] <= val;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_pos <= '0;
      sub_pos  <= '0;
    end else if (cmd.buf_wr) begin
      if (stat.sub_end) begin
        elem_pos <= '0;
        cur_sub  <= sub_pos;
        sub_pos  <= ({1'b0, sub_pos} + 6'd1 >= eff_m) ? 5'd0 : sub_pos + 5'd1;
        res_last <= ({1'b0, sub_pos} + 6'd1 >= eff_m);
      end else begin
        elem_pos <= elem_pos + 3'd1;
      end
    end else if (cmd.out_load && cmd.out_kind) begin
      res_last <= 1'b1;
    end
  end

  // scan counters: one element of one centroid per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sc_cent <= '0;
      sc_elem <= '0;
    end else if (cmd.scan_step) begin
      if (stat.elem_last) begin
        sc_elem <= '0;
        sc_cent <= sc_cent + 8'd1;
      end else begin
        sc_elem <= sc_elem + 3'd1;
      end
    end
  end

  // stage 1: centroid element read
  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else p1_v <= cmd.scan_step;
    p1_cv     <= cstore[{cur_sub, sc_cent, sc_elem}];
    p1_cent   <= sc_cent;
    p1_elem   <= sc_elem;
    p1_first  <= (sc_elem == 3'd0);
    p1_lastel <= stat.elem_last;
  end

  // stage 2: square of difference
  assign diff = $signed({sbuf[p1_elem][15], sbuf[p1_elem]}) - $signed({p1_cv[15], p1_cv});
  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else p2_v <= p1_v;
    p2_sq     <= 32'(diff * diff);
    p2_cent   <= p1_cent;
    p2_first  <= p1_first;
    p2_lastel <= p1_lastel;
  end

  // stage 3: accumulate and compare
  assign full_d = (p2_first ? '0 : dsum) + DistW'(p2_sq);
  always_ff @(posedge clk) begin
    if (p2_v) begin
      dsum <= full_d;
      if (p2_lastel) begin
        if (cmd.tab_wr) dtable[{cur_sub, p2_cent}] <= full_d;
        if (p2_cent == 8'd0 || full_d < best) begin
          best   <= full_d;
          best_c <= p2_cent;
        end
      end
    end
  end

  // table lookup and accumulator
  always_ff @(posedge clk) begin
    tab_q <= dtable[{code_pos, code}];
  end
  assign acc_sum = {1'b0, acc} + (AccW+1)'(tab_q);
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      code_pos <= '0;
    end else if (cmd.acc_step) begin
      if (stat.code_end) begin
        acc      <= '0;
        code_pos <= '0;
        res_dist <= acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
      end else begin
        acc      <= acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
        code_pos <= code_pos + 5'd1;
      end
    end
  end

  assign res_kind = (act == ActCode);
  assign res_code = res_kind ? 8'd0 : best_c;
  assign res_sub  = res_kind ? 5'd0 : cur_sub;

endmodule

[rtl/core/product_quantizer_encode_adc.sv]
// ----------------------------------------------------------------------------
// product_quantizer_encode_adc
// Product-quantization encoder and asymmetric distance engine.
// ----------------------------------------------------------------------------
// One item at a time. A centroid write or a non-final element is only decoded.
// An element that closes a subvector starts a scan of the centroid store, one
// element per cycle, set by the single store read port; the scan of an encode
// element ends with its result. A code byte takes a table read, then an add.
// A result sits in an output register and does not block the next item; a
// following result waits in the engine until the register is free.
module product_quantizer_encode_adc (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sub_select, centroid_select, element_select,
                                 // value, code_in
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // code_out, sub_out, distance_sum, zero pad
  output logic        m_tuser,   // result_kind
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import pqe_pkg::*;

  pqe_cmd_t  cmd;
  pqe_stat_t stat;
  logic busy, in_fire, rk, rl;
  logic [7:0]  rc;
  logic [4:0]  rs;
  logic [43:0] rd;

  assign s_tready  = !busy;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  pqe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!m_tvalid),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  pqe_dpath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_action(s_tuser), .in_sub(s_tdata[4:0]), .in_cent(s_tdata[12:5]),
    .in_elem(s_tdata[15:13]), .in_value(s_tdata[31:16]), .in_code(s_tdata[39:32]),
    .stat(stat), .res_kind(rk), .res_code(rc), .res_sub(rs), .res_dist(rd),
    .res_last(rl)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {7'd0, (rk ? rd : 44'd0), rs, rc};
      m_tuser <= rk;
      m_tlast <= rk | rl;
    end
  end

endmodule

[rtl/core/pqe_checker.sv]
// ----------------------------------------------------------------------------
// pqe_checker
// Port-level checks of the encode/ADC engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pqe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  `CHK_IMPLY(a_code_fields, clk, rst, m_tvalid && !m_tuser, m_tdata[63:13] == 51'd0, "code dist set")
  `CHK_IMPLY(a_dist_last, clk, rst, m_tvalid && m_tuser, m_tlast, "distance without last")
  `CHK_IMPLY(a_dist_fields, clk, rst, m_tvalid && m_tuser, m_tdata[12:0] == 13'd0, "dist code set")
  `CHK_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule

bind product_quantizer_encode_adc pqe_checker u_chk (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
